/* design/bvm_pkg.sv */
// Shared types and constants for the byte VM instruction executor.
// No dependencies; imported by every module of the block.
`default_nettype none

package bvm_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ILLEGAL   = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    // Instruction classes (bits 15..12)
    localparam logic [3:0] CLS_SYS   = 4'h0;
    localparam logic [3:0] CLS_JUMP  = 4'h1;
    localparam logic [3:0] CLS_CALL  = 4'h2;
    localparam logic [3:0] CLS_SEQI  = 4'h3;
    localparam logic [3:0] CLS_SNEI  = 4'h4;
    localparam logic [3:0] CLS_SEQR  = 4'h5;
    localparam logic [3:0] CLS_LDI   = 4'h6;
    localparam logic [3:0] CLS_ADDI  = 4'h7;
    localparam logic [3:0] CLS_ALU   = 4'h8;
    localparam logic [3:0] CLS_SNER  = 4'h9;
    localparam logic [3:0] CLS_LDIDX = 4'hA;
    localparam logic [3:0] CLS_JMPV  = 4'hB;
    localparam logic [3:0] CLS_RAND  = 4'hC;

    // Register-register operations (bits 3..0 of class 8)
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Whole-word system instructions
    localparam logic [15:0] INS_CLEAR  = 16'h00E0;
    localparam logic [15:0] INS_RETURN = 16'h00EE;

    localparam logic [3:0]  REG_FLAG = 4'hF;
    localparam logic [11:0] PC_RESET = 12'd512;
    localparam int          STACK_DEPTH_DEF = 16;

    // Register file write port
    typedef struct packed {
        logic       en;
        logic [3:0] addr;
        logic [7:0] data;
    } t_rf_wr;

endpackage

`default_nettype wire

/* design/bvm_regfile.sv */
// Data register memory: 16 x 8, two synchronous read ports, one write port.
// Depends on bvm_pkg for the write port struct; unwritten entries read as zero.
`default_nettype none

module bvm_regfile (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_rd_en,
    input  wire logic [3:0]      i_rd_addr_a,
    input  wire logic [3:0]      i_rd_addr_b,
    input  wire bvm_pkg::t_rf_wr i_wr,
    output logic [7:0]           o_rd_data_a,
    output logic [7:0]           o_rd_data_b
);
    import bvm_pkg::*;

    logic [7:0]  r_mem [16];
    logic [15:0] r_written;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Mark entries written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr.en) begin
            r_written[i_wr.addr] <= 1'b1;
        end
    end

    // Registered reads, held while no new request is taken
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data_a <= r_written[i_rd_addr_a] ? r_mem[i_rd_addr_a] : 8'd0;
            o_rd_data_b <= r_written[i_rd_addr_b] ? r_mem[i_rd_addr_b] : 8'd0;
        end
    end

endmodule

`default_nettype wire

/* design/bvm_stack.sv */
// Return stack memory: STACK_DEPTH x 12, one synchronous read, one write.
// Depends on bvm_pkg for the default depth.
`default_nettype none

module bvm_stack #(
    parameter int STACK_DEPTH = bvm_pkg::STACK_DEPTH_DEF,
    parameter int AW          = $clog2(STACK_DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [11:0]   i_wr_data,
    output logic [11:0]        o_rd_data
);
    import bvm_pkg::*;

    logic [11:0] r_mem [STACK_DEPTH];

    // Push
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read of the top entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/byte_vm_instruction_executor.sv */
// Top level of the byte VM instruction executor: decode, execute, state update.
// Depends on bvm_pkg, bvm_regfile and bvm_stack.
//
//  Channel   Direction  Handshake                  Payload
//  request   in         i_in_valid / o_in_ready    i_instruction, i_random_byte
//  result    out        o_out_valid / i_out_ready  o_status .. o_clear_screen
//
// One instruction is taken per cycle while results are taken; memory is read at the accepting edge,
// then the instruction is executed and its result written back into the output register.
// Back-to-back register and stack hazards are covered by write forwarding.
// Reset sets pc to 512 and clears registers, index, stack pointer and valids;
// no request is taken while reset is held.
// A result not taken holds the execute stage, and with it new requests.
`default_nettype none

module byte_vm_instruction_executor #(
    parameter int STACK_DEPTH = bvm_pkg::STACK_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_instruction,
    input  wire logic [7:0]  i_random_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [11:0]      o_program_counter,
    output logic [11:0]      o_index_value,
    output logic             o_reg_written,
    output logic [3:0]       o_reg_number,
    output logic [7:0]       o_reg_value,
    output logic [7:0]       o_flag_value,
    output logic             o_clear_screen
);
    import bvm_pkg::*;

    localparam int AW   = $clog2(STACK_DEPTH);
    localparam int SP_W = $clog2(STACK_DEPTH + 1);

    // Architectural state held in flops
    logic [11:0]     r_pc, n_pc;
    logic [11:0]     r_index, n_index;
    logic [SP_W-1:0] r_sp, n_sp;
    logic [7:0]      r_vf, n_vf;

    // Execute stage
    logic            r_s1_valid;
    logic [15:0]     r_s1_ins;
    logic [7:0]      r_s1_rnd;
    logic [AW-1:0]   r_s1_stk_addr;
    t_rf_wr          r_fwd;
    logic            r_sfwd_en;
    logic [AW-1:0]   r_sfwd_addr;
    logic [11:0]     r_sfwd_data;

    logic            accept, commit;
    logic [3:0]      rd_addr_b;
    logic [AW-1:0]   stk_rd_addr;
    logic [SP_W-1:0] sp_dec;
    logic [7:0]      rf_rd_a, rf_rd_b;
    logic [11:0]     stk_rd;

    // Decode fields
    logic [3:0]  cls, x, y, n;
    logic [7:0]  nn;
    logic [11:0] nnn;
    logic [7:0]  vx, vy, res, reg_out;
    logic [8:0]  sum9;
    logic [11:0] ret_addr;
    logic        wr, has_flag, flag, skip, clr;
    t_status     status;
    t_rf_wr      rf_wr;
    logic        stk_we;

    assign cls = r_s1_ins[15:12];
    assign x   = r_s1_ins[11:8];
    assign y   = r_s1_ins[7:4];
    assign n   = r_s1_ins[3:0];
    assign nn  = r_s1_ins[7:0];
    assign nnn = r_s1_ins[11:0];

    // Handshake
    assign commit     = r_s1_valid && (!o_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_s1_valid || commit);
    assign accept     = i_in_valid && o_in_ready;

    // Read addresses: class B reads V0 on the second port
    assign rd_addr_b = (i_instruction[15:12] == CLS_JMPV) ? 4'd0 : i_instruction[7:4];
    assign sp_dec    = n_sp - SP_W'(1);
    assign stk_rd_addr = sp_dec[AW-1:0];

    // Operands: VF from its flop, else forward the write committed as this instruction was accepted
    always_comb begin
        if (x == REG_FLAG) begin
            vx = r_vf;
        end else if (r_fwd.en && r_fwd.addr == x) begin
            vx = r_fwd.data;
        end else begin
            vx = rf_rd_a;
        end
        if (cls == CLS_JMPV) begin
            vy = (r_fwd.en && r_fwd.addr == 4'd0) ? r_fwd.data : rf_rd_b;
        end else if (y == REG_FLAG) begin
            vy = r_vf;
        end else if (r_fwd.en && r_fwd.addr == y) begin
            vy = r_fwd.data;
        end else begin
            vy = rf_rd_b;
        end
        ret_addr = (r_sfwd_en && r_sfwd_addr == r_s1_stk_addr) ? r_sfwd_data : stk_rd;
    end

    // Execute
    always_comb begin
        status   = ST_OK;
        wr       = 1'b0;
        has_flag = 1'b0;
        flag     = 1'b0;
        skip     = 1'b0;
        clr      = 1'b0;
        res      = 8'd0;
        sum9     = 9'd0;
        stk_we   = 1'b0;
        n_pc     = r_pc;
        n_index  = r_index;
        n_sp     = r_sp;
        case (cls)
            CLS_SYS: begin
                if (r_s1_ins == INS_CLEAR) begin
                    clr = 1'b1;
                end else if (r_s1_ins == INS_RETURN) begin
                    if (r_sp == '0) begin
                        status = ST_UNDERFLOW;
                    end else begin
                        n_sp = r_sp - SP_W'(1);
                        n_pc = ret_addr;
                    end
                end else begin
                    status = ST_ILLEGAL;
                end
            end
            CLS_JUMP: n_pc = nnn;
            CLS_CALL: begin
                if (r_sp >= SP_W'(STACK_DEPTH)) begin
                    status = ST_OVERFLOW;
                end else begin
                    stk_we = 1'b1;
                    n_sp   = r_sp + SP_W'(1);
                    n_pc   = nnn;
                end
            end
            CLS_SEQI: skip = (vx == nn);
            CLS_SNEI: skip = (vx != nn);
            CLS_SEQR: skip = (vx == vy);
            CLS_LDI: begin
                wr  = 1'b1;
                res = nn;
            end
            CLS_ADDI: begin
                wr  = 1'b1;
                res = vx + nn;
            end
            CLS_ALU: begin
                wr = 1'b1;
                case (n)
                    ALU_MOV: res = vy;
                    ALU_OR:  res = vx | vy;
                    ALU_AND: res = vx & vy;
                    ALU_XOR: res = vx ^ vy;
                    ALU_ADD: begin
                        sum9     = {1'b0, vx} + {1'b0, vy};
                        res      = sum9[7:0];
                        has_flag = 1'b1;
                        flag     = sum9[8];
                    end
                    ALU_SUB: begin
                        res      = vx - vy;
                        has_flag = 1'b1;
                        flag     = (vx >= vy);
                    end
                    ALU_SHR: begin
                        res      = {1'b0, vx[7:1]};
                        has_flag = 1'b1;
                        flag     = vx[0];
                    end
                    ALU_SUBN: begin
                        res      = vy - vx;
                        has_flag = 1'b1;
                        flag     = (vy >= vx);
                    end
                    ALU_SHL: begin
                        res      = {vx[6:0], 1'b0};
                        has_flag = 1'b1;
                        flag     = vx[7];
                    end
                    default: begin
                        wr     = 1'b0;
                        status = ST_ILLEGAL;
                    end
                endcase
            end
            CLS_SNER:  skip = (vx != vy);
            CLS_LDIDX: n_index = nnn;
            CLS_JMPV:  n_pc = {4'd0, vy} + nnn;
            CLS_RAND: begin
                wr  = 1'b1;
                res = r_s1_rnd & nn;
            end
            default: status = ST_ILLEGAL;
        endcase

        if (skip) begin
            n_pc = r_pc + 12'd2;
        end

        // Flag overrides VF; a plain write to VF lands in the flop too
        if (has_flag) begin
            n_vf = {7'd0, flag};
        end else if (wr && x == REG_FLAG) begin
            n_vf = res;
        end else begin
            n_vf = r_vf;
        end
        reg_out = (x == REG_FLAG) ? n_vf : res;

        // Drop all updates unless the stage commits
        if (!commit) begin
            n_pc    = r_pc;
            n_index = r_index;
            n_sp    = r_sp;
            n_vf    = r_vf;
            stk_we  = 1'b0;
        end
        rf_wr.en   = commit && wr;
        rf_wr.addr = x;
        rf_wr.data = res;
    end

    bvm_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (accept),
        .i_rd_addr_a (i_instruction[11:8]),
        .i_rd_addr_b (rd_addr_b),
        .i_wr        (rf_wr),
        .o_rd_data_a (rf_rd_a),
        .o_rd_data_b (rf_rd_b)
    );

    bvm_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .AW          (AW)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (stk_rd_addr),
        .i_wr_en   (stk_we),
        .i_wr_addr (r_sp[AW-1:0]),
        .i_wr_data (r_pc),
        .o_rd_data (stk_rd)
    );

    // State, stage and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= PC_RESET;
            r_index     <= '0;
            r_sp        <= '0;
            r_vf        <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd.en    <= 1'b0;
            r_sfwd_en   <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            r_pc    <= n_pc;
            r_index <= n_index;
            r_sp    <= n_sp;
            r_vf    <= n_vf;

            // Advance the execute stage
            if (accept) begin
                r_s1_valid <= 1'b1;
                r_fwd.en   <= rf_wr.en;
                r_fwd.addr <= rf_wr.addr;
                r_fwd.data <= rf_wr.data;
                r_sfwd_en  <= stk_we;
            end else if (commit) begin
                r_s1_valid <= 1'b0;
            end

            // Hold the result until taken
            if (commit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ins      <= i_instruction;
            r_s1_rnd      <= i_random_byte;
            r_s1_stk_addr <= stk_rd_addr;
            r_sfwd_addr   <= r_sp[AW-1:0];
            r_sfwd_data   <= r_pc;
        end
        if (commit) begin
            o_status          <= status;
            o_program_counter <= n_pc;
            o_index_value     <= n_index;
            o_reg_written     <= wr;
            o_reg_number      <= wr ? x : 4'd0;
            o_reg_value       <= wr ? reg_out : 8'd0;
            o_flag_value      <= n_vf;
            o_clear_screen    <= clr;
        end
    end

endmodule

`default_nettype wire
